// File: rtl/core/ntps_pkg.sv
package ntps_pkg;

    // defaults for the top level parameters
    localparam int DEF_MAX_SERVERS = 8;
    localparam int DEF_LOCAL_ADDRS = 4;

    // retry attempts per probe are 0..RETRY_LIMIT
    localparam logic [1:0] RETRY_LIMIT = 2'd3;

    // config register indexes (byte address is 4 * index)
    localparam logic [2:0] REG_SERVER_COUNT   = 3'd0;
    localparam logic [2:0] REG_LOCAL_PORT     = 3'd1;
    localparam logic [2:0] REG_LOCAL_IP_A     = 3'd2;
    localparam logic [2:0] REG_LOCAL_IP_B     = 3'd3;
    localparam logic [2:0] REG_LOCAL_IP_C     = 3'd4;
    localparam logic [2:0] REG_LOCAL_IP_D     = 3'd5;
    localparam logic [2:0] REG_LOCAL_IP_VALID = 3'd6;

    // input event codes
    localparam logic [2:0] MODE_START      = 3'd0;
    localparam logic [2:0] MODE_START_UPNP = 3'd1;
    localparam logic [2:0] MODE_SAME_REPLY = 3'd2;
    localparam logic [2:0] MODE_DIFFIP_REPLY = 3'd3;
    localparam logic [2:0] MODE_DIFFPORT_REPLY = 3'd4;
    localparam logic [2:0] MODE_UPNP_REPLY = 3'd5;
    localparam logic [2:0] MODE_TIMEOUT    = 3'd6;

    // result kinds
    localparam logic [1:0] RES_PROBE  = 2'd0;
    localparam logic [1:0] RES_REPORT = 2'd1;
    localparam logic [1:0] RES_UPNP   = 2'd2;

    // probe kinds
    localparam logic [1:0] PROBE_SAME     = 2'd0;
    localparam logic [1:0] PROBE_DIFFIP   = 2'd1;
    localparam logic [1:0] PROBE_DIFFPORT = 2'd2;
    localparam logic [1:0] PROBE_UPNP     = 2'd3;

    // nat types
    localparam logic [2:0] NAT_ERROR         = 3'd0;
    localparam logic [2:0] NAT_PUBLIC        = 3'd1;
    localparam logic [2:0] NAT_FULL_CONE     = 3'd2;
    localparam logic [2:0] NAT_SYMMETRIC     = 3'd3;
    localparam logic [2:0] NAT_IP_RESTRICTED = 3'd4;
    localparam logic [2:0] NAT_PORT_RESTRICTED = 3'd5;

    typedef enum logic [6:0] {
        PH_IDLE   = 7'b0000001,
        PH_SAME   = 7'b0000010,
        PH_DIFFIP = 7'b0000100,
        PH_SYM    = 7'b0001000,
        PH_RESTR  = 7'b0010000,
        PH_UPNP   = 7'b0100000,
        PH_DONE   = 7'b1000000
    } phase_t;

    typedef struct packed {
        logic [15:0] port_value;
        logic [2:0]  nat_class;
        logic [1:0]  attempt;
        logic [2:0]  server_index;
        logic [1:0]  probe_kind;
        logic [1:0]  result_kind;
    } out_item_t;

endpackage

// File: rtl/core/nat_type_probe_sequencer_core.sv
// NAT type probe sequencer. Each item on the s_ channel is one event (start, start upnp, one
// of four server replies, or a timeout) and gives zero or one result item on the m_ channel:
// a probe to send, a NAT type report, or a upnp result. Every event is handled by the
// combinational phase logic and its result is registered, so one item can be taken each
// clock; a result that the sink does not take lands in a one-item skid register, and only
// while that skid register is full is s_tready low. Replies that do not fit the current
// phase, timeouts in idle or complete, and mode 7 give no result and change nothing. The
// user writes configuration through the APB port only while no event is in flight; the
// block does not enforce this. Registers read back as written, unused upper bits zero.
module nat_type_probe_sequencer_core #(
    parameter int MAX_SERVERS = ntps_pkg::DEF_MAX_SERVERS,
    parameter int LOCAL_ADDRS = ntps_pkg::DEF_LOCAL_ADDRS
) (
    input  logic        aclk,
    input  logic        aresetn,

    // event input
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,    // reply_ip[31:0], reply_port[47:32], upnp_port[63:48]
    input  logic [2:0]  s_tuser,    // mode[2:0]

    // result output
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,    // probe_kind[1:0], server_index[4:2], attempt[6:5],
                                    // nat_class[9:7], port_value[25:10], zero fill [31:26]
    output logic [1:0]  m_tuser,    // result_kind[1:0]

    // config port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import ntps_pkg::*;

    localparam logic [4:0] MaxSrv = 5'(MAX_SERVERS);

    // config registers
    logic [3:0]  server_count_reg;
    logic [15:0] local_port_reg;
    logic [31:0] local_ip_reg [4];
    logic [3:0]  local_ip_valid_reg;

    // probe state
    phase_t      phase_reg, phase_next;
    logic [1:0]  retry_reg, retry_next;
    logic        behind_nat_reg, behind_nat_next;
    logic [31:0] first_ip_reg, first_ip_next;
    logic [15:0] first_port_reg, first_port_next;
    logic [3:0]  next_server_reg, next_server_next;
    logic [2:0]  primary_reg, primary_next;
    logic [2:0]  secondary_reg, secondary_next;
    logic [15:0] upnp_port_reg, upnp_port_next;

    // output register and skid register
    logic        m_valid_reg;
    out_item_t   m_item_reg;
    logic        skid_valid_reg;
    out_item_t   skid_item_reg;

    logic        in_accept;
    logic        cfg_write;
    logic [2:0]  cfg_index;
    logic [2:0]  mode;
    logic [31:0] reply_ip;
    logic [15:0] reply_port;
    logic [15:0] upnp_port;

    logic [3:0]  eff_count;
    logic        server_left;
    logic        ip_hit;
    logic        is_local;
    logic        do_probe;
    logic        do_report;
    logic        do_upnp;
    logic [2:0]  report_type;
    logic [15:0] upnp_value;
    logic        res_valid;
    out_item_t   res_item;

    // ---------------------------------------------------------------- config port
    assign pready    = 1'b1;
    assign cfg_write = psel & penable & pwrite & pready;
    assign cfg_index = paddr[4:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            server_count_reg   <= '0;
            local_port_reg     <= '0;
            local_ip_reg[0]    <= '0;
            local_ip_reg[1]    <= '0;
            local_ip_reg[2]    <= '0;
            local_ip_reg[3]    <= '0;
            local_ip_valid_reg <= '0;
        end else if (cfg_write) begin
            unique case (cfg_index)
                REG_SERVER_COUNT:   server_count_reg   <= pwdata[3:0];
                REG_LOCAL_PORT:     local_port_reg     <= pwdata[15:0];
                REG_LOCAL_IP_A:     local_ip_reg[0]    <= pwdata;
                REG_LOCAL_IP_B:     local_ip_reg[1]    <= pwdata;
                REG_LOCAL_IP_C:     local_ip_reg[2]    <= pwdata;
                REG_LOCAL_IP_D:     local_ip_reg[3]    <= pwdata;
                REG_LOCAL_IP_VALID: local_ip_valid_reg <= pwdata[3:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_index)
            REG_SERVER_COUNT:   prdata = {28'd0, server_count_reg};
            REG_LOCAL_PORT:     prdata = {16'd0, local_port_reg};
            REG_LOCAL_IP_A:     prdata = local_ip_reg[0];
            REG_LOCAL_IP_B:     prdata = local_ip_reg[1];
            REG_LOCAL_IP_C:     prdata = local_ip_reg[2];
            REG_LOCAL_IP_D:     prdata = local_ip_reg[3];
            REG_LOCAL_IP_VALID: prdata = {28'd0, local_ip_valid_reg};
            default:            prdata = '0;
        endcase
    end

    // ---------------------------------------------------------------- input side
    // input is held off only while a result sits in the skid register
    assign s_tready   = ~skid_valid_reg;
    assign in_accept  = s_tvalid & s_tready;
    assign mode       = s_tuser;
    assign reply_ip   = s_tdata[31:0];
    assign reply_port = s_tdata[47:32];
    assign upnp_port  = s_tdata[63:48];

    // server count limited to the list size
    assign eff_count   = ({1'b0, server_count_reg} > MaxSrv) ? MaxSrv[3:0] : server_count_reg;
    assign server_left = next_server_reg < eff_count;

    // reflected address equal to one of the enabled local addresses and the local port
    always_comb begin
        ip_hit = 1'b0;
        for (int i = 0; i < LOCAL_ADDRS; i++) begin
            if (local_ip_valid_reg[i] && local_ip_reg[i] == reply_ip) begin
                ip_hit = 1'b1;
            end
        end
    end
    assign is_local = ip_hit & (local_port_reg == reply_port);

    // ---------------------------------------------------------------- phase logic
    always_comb begin
        phase_next       = phase_reg;
        retry_next       = retry_reg;
        behind_nat_next  = behind_nat_reg;
        first_ip_next    = first_ip_reg;
        first_port_next  = first_port_reg;
        next_server_next = next_server_reg;
        primary_next     = primary_reg;
        secondary_next   = secondary_reg;
        upnp_port_next   = upnp_port_reg;
        do_probe         = 1'b0;
        do_report        = 1'b0;
        do_upnp          = 1'b0;
        report_type      = NAT_ERROR;
        upnp_value       = '0;

        unique case (mode)
            MODE_START: begin
                // restart from any phase
                retry_next = '0;
                if (eff_count == '0) begin
                    do_report = 1'b1;
                end else begin
                    primary_next     = '0;
                    next_server_next = 4'd1;
                    phase_next       = PH_SAME;
                    do_probe         = 1'b1;
                end
            end
            MODE_START_UPNP: begin
                retry_next     = '0;
                upnp_port_next = upnp_port;
                phase_next     = PH_UPNP;
                do_probe       = 1'b1;
            end
            MODE_SAME_REPLY: begin
                if (phase_reg == PH_SAME) begin
                    // first reflection, kept for the symmetric check
                    first_ip_next   = reply_ip;
                    first_port_next = reply_port;
                    behind_nat_next = ~is_local;
                    retry_next      = '0;
                    phase_next      = PH_DIFFIP;
                    do_probe        = 1'b1;
                end else if (phase_reg == PH_SYM) begin
                    if (reply_ip != first_ip_reg || reply_port != first_port_reg) begin
                        do_report   = 1'b1;
                        report_type = NAT_SYMMETRIC;
                    end else begin
                        retry_next = '0;
                        phase_next = PH_RESTR;
                        do_probe   = 1'b1;
                    end
                end
            end
            MODE_DIFFIP_REPLY: begin
                if (phase_reg == PH_DIFFIP) begin
                    do_report   = 1'b1;
                    report_type = behind_nat_reg ? NAT_FULL_CONE : NAT_PUBLIC;
                end
            end
            MODE_DIFFPORT_REPLY: begin
                if (phase_reg == PH_RESTR) begin
                    do_report   = 1'b1;
                    report_type = NAT_IP_RESTRICTED;
                end
            end
            MODE_UPNP_REPLY: begin
                if (phase_reg == PH_UPNP) begin
                    do_upnp    = 1'b1;
                    upnp_value = upnp_port;
                end
            end
            MODE_TIMEOUT: begin
                if (phase_reg != PH_IDLE && phase_reg != PH_DONE) begin
                    if (retry_reg < RETRY_LIMIT) begin
                        // resend the same probe
                        retry_next = retry_reg + 2'd1;
                        do_probe   = 1'b1;
                    end else begin
                        // retries used up: fall over to the next server or give up
                        unique case (phase_reg)
                            PH_SAME: begin
                                if (server_left) begin
                                    primary_next     = next_server_reg[2:0];
                                    next_server_next = next_server_reg + 4'd1;
                                    retry_next       = '0;
                                    do_probe         = 1'b1;
                                end else begin
                                    do_report = 1'b1;
                                end
                            end
                            PH_DIFFIP: begin
                                if (!behind_nat_reg) begin
                                    do_report   = 1'b1;
                                    report_type = NAT_SYMMETRIC;
                                end else begin
                                    retry_next = '0;
                                    phase_next = PH_SYM;
                                    if (server_left) begin
                                        secondary_next   = next_server_reg[2:0];
                                        next_server_next = next_server_reg + 4'd1;
                                        do_probe         = 1'b1;
                                    end else begin
                                        do_report = 1'b1;
                                    end
                                end
                            end
                            PH_SYM: begin
                                if (server_left) begin
                                    secondary_next   = next_server_reg[2:0];
                                    next_server_next = next_server_reg + 4'd1;
                                    retry_next       = '0;
                                    do_probe         = 1'b1;
                                end else begin
                                    do_report = 1'b1;
                                end
                            end
                            PH_RESTR: begin
                                do_report   = 1'b1;
                                report_type = NAT_PORT_RESTRICTED;
                            end
                            default: begin
                                // upnp phase: report failure with port zero
                                do_upnp = 1'b1;
                            end
                        endcase
                    end
                end
            end
            default: ;
        endcase

        // every report and upnp result ends the check
        if (do_report || do_upnp) begin
            phase_next = PH_DONE;
        end
    end

    // ---------------------------------------------------------------- result build
    always_comb begin
        res_item = '0;
        if (do_report) begin
            res_item.result_kind = RES_REPORT;
            res_item.nat_class   = report_type;
        end else if (do_upnp) begin
            res_item.result_kind = RES_UPNP;
            res_item.port_value  = upnp_value;
        end else begin
            // probe for the phase being entered
            res_item.result_kind  = RES_PROBE;
            res_item.attempt      = retry_next;
            res_item.server_index = primary_next;
            unique case (phase_next)
                PH_SAME:   res_item.probe_kind = PROBE_SAME;
                PH_DIFFIP: res_item.probe_kind = PROBE_DIFFIP;
                PH_SYM: begin
                    res_item.probe_kind   = PROBE_SAME;
                    res_item.server_index = secondary_next;
                end
                PH_RESTR:  res_item.probe_kind = PROBE_DIFFPORT;
                default: begin
                    res_item.probe_kind = PROBE_UPNP;
                    res_item.port_value = upnp_port_next;
                end
            endcase
        end
    end

    assign res_valid = in_accept & (do_probe | do_report | do_upnp);

    // ---------------------------------------------------------------- state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg       <= PH_IDLE;
            retry_reg       <= '0;
            behind_nat_reg  <= 1'b0;
            first_ip_reg    <= '0;
            first_port_reg  <= '0;
            next_server_reg <= '0;
            primary_reg     <= '0;
            secondary_reg   <= '0;
            upnp_port_reg   <= '0;
        end else if (in_accept) begin
            phase_reg       <= phase_next;
            retry_reg       <= retry_next;
            behind_nat_reg  <= behind_nat_next;
            first_ip_reg    <= first_ip_next;
            first_port_reg  <= first_port_next;
            next_server_reg <= next_server_next;
            primary_reg     <= primary_next;
            secondary_reg   <= secondary_next;
            upnp_port_reg   <= upnp_port_next;
        end
    end

    // ---------------------------------------------------------------- output and skid
    // a new result goes to the skid register only when the output register is stalled;
    // the skid register drains into the output register as soon as the sink takes one
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg    <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            if (m_valid_reg && !m_tready) begin
                if (res_valid) begin
                    skid_valid_reg <= 1'b1;
                end
            end else if (skid_valid_reg) begin
                m_valid_reg    <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                m_valid_reg <= res_valid;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (m_valid_reg && !m_tready) begin
            if (res_valid) begin
                skid_item_reg <= res_item;
            end
        end else if (skid_valid_reg) begin
            m_item_reg <= skid_item_reg;
        end else if (res_valid) begin
            m_item_reg <= res_item;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_item_reg.result_kind;
    assign m_tdata  = {6'd0, m_item_reg.port_value, m_item_reg.nat_class, m_item_reg.attempt,
                       m_item_reg.server_index, m_item_reg.probe_kind};

endmodule
